// ===== rtl/aes_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_pkg
// shared types, substitution tables and field arithmetic for the aes block
// ----------------------------------------------------------------------------
package aes_pkg;

	localparam int NUM_RK = 15;
	localparam int MAX_ROUNDS = 14;

	localparam logic [1:0] KLEN_128 = 2'd0;
	localparam logic [1:0] KLEN_192 = 2'd1;
	localparam logic [1:0] KLEN_256 = 2'd2;

	localparam logic [2:0] REG_KEY_LENGTH = 3'd0;
	localparam logic [2:0] REG_KEY_PART_0 = 3'd1;
	localparam logic [2:0] REG_KEY_PART_1 = 3'd2;
	localparam logic [2:0] REG_KEY_PART_2 = 3'd3;
	localparam logic [2:0] REG_KEY_PART_3 = 3'd4;

	localparam logic [7:0] RCON_INIT = 8'h01;
	localparam logic [7:0] GF_POLY = 8'h1b;

	typedef logic [127:0] rkey_t;

	typedef struct packed {
		logic       busy;
		logic [1:0] klen;
	} key_status_t;

	localparam logic [2047:0] FWD_SBOX = {
		256'h637c777bf26b6fc53001672bfed7ab76ca82c97dfa5947f0add4a2af9ca472c0,
		256'hb7fd9326363ff7cc34a5e5f171d8311504c723c31896059a071280e2eb27b275,
		256'h09832c1a1b6e5aa0523bd6b329e32f8453d100ed20fcb15b6acbbe394a4c58cf,
		256'hd0efaafb434d338545f9027f503c9fa851a3408f929d38f5bcb6da2110fff3d2,
		256'hcd0c13ec5f974417c4a77e3d645d197360814fdc222a908846eeb814de5e0bdb,
		256'he0323a0a4906245cc2d3ac629195e479e7c8376d8dd54ea96c56f4ea657aae08,
		256'hba78252e1ca6b4c6e8dd741f4bbd8b8a703eb5664803f60e613557b986c11d9e,
		256'he1f8981169d98e949b1e87e9ce5528df8ca1890dbfe6426841992d0fb054bb16
	};

	localparam logic [2047:0] INV_SBOX = {
		256'h52096ad53036a538bf40a39e81f3d7fb7ce339829b2fff87348e4344c4dee9cb,
		256'h547b9432a6c2233dee4c950b42fac34e082ea16628d924b2765ba2496d8bd125,
		256'h72f8f66486689816d4a45ccc5d65b6926c704850fdedb9da5e154657a78d9d84,
		256'h90d8ab008cbcd30af7e45805b8b34506d02c1e8fca3f0f02c1afbd0301138a6b,
		256'h3a9111414f67dcea97f2cfcef0b4e67396ac7422e7ad3585e2f937e81c75df6e,
		256'h47f11a711d29c5896fb7620eaa18be1bfc563e4bc6d279209adbc0fe78cd5af4,
		256'h1fdda8338807c731b11210592780ec5f60517fa919b54a0d2de57a9f93c99cef,
		256'ha0e03b4dae2af5b0c8ebbb3c83539961172b047eba77d626e169146355210c7d
	};

	function automatic logic [7:0] sbox(input logic [7:0] b);
		return FWD_SBOX[{~b, 3'b111} -: 8];
	endfunction

	function automatic logic [7:0] inv_sbox(input logic [7:0] b);
		return INV_SBOX[{~b, 3'b111} -: 8];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? GF_POLY : 8'h00);
	endfunction

	function automatic logic [31:0] subst_word(input logic [31:0] w);
		return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
	endfunction

endpackage

// ===== rtl/aes_key_expand.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_key_expand
// key registers and a one-word-per-cycle round key expansion sequencer
// ----------------------------------------------------------------------------
module aes_key_expand import aes_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output rkey_t       round_keys [NUM_RK],
	output key_status_t status
);

	logic [1:0]  klen_q;
	logic [63:0] kp_q [4];
	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [2:0]  mod_q;
	logic [7:0]  rc_q;
	logic [31:0] win_q [8];
	rkey_t       rk_q [NUM_RK];

	logic        start;
	logic [3:0]  nk;
	logic [5:0]  total;
	logic [31:0] key_word;
	logic [31:0] prev;
	logic [31:0] back;
	logic [31:0] tmp;
	logic [31:0] word;
	logic        wrap;

	always_comb begin
		start = 1'b0;
		if (cfg_we) begin
			unique case (cfg_index)
				REG_KEY_LENGTH, REG_KEY_PART_0, REG_KEY_PART_1,
				REG_KEY_PART_2, REG_KEY_PART_3: start = 1'b1;
				default: start = 1'b0;
			endcase
		end
	end

	always_comb begin
		unique case (klen_q)
			KLEN_128: nk = 4'd4;
			KLEN_192: nk = 4'd6;
			default:  nk = 4'd8;
		endcase
		total = {nk + 4'd7, 2'b00};
		key_word = cnt_q[0] ? kp_q[cnt_q[2:1]][31:0] : kp_q[cnt_q[2:1]][63:32];
		prev = win_q[0];
		back = win_q[3'(nk - 4'd1)];
		tmp = prev;
		if (mod_q == 3'd0)
			tmp = subst_word({prev[23:0], prev[31:24]}) ^ {rc_q, 24'h0};
		else if (nk == 4'd8 && mod_q == 3'd4)
			tmp = subst_word(prev);
		word = ({2'b00, cnt_q} < 8'(nk)) ? key_word : (back ^ tmp);
		wrap = (4'(mod_q) == nk - 4'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			klen_q <= KLEN_128;
			for (int i = 0; i < 4; i++) kp_q[i] <= '0;
			busy_q <= 1'b1;
			cnt_q <= '0;
			mod_q <= '0;
			rc_q <= RCON_INIT;
		end else if (start) begin
			unique case (cfg_index)
				REG_KEY_LENGTH: klen_q <= cfg_data[1:0];
				REG_KEY_PART_0: kp_q[0] <= cfg_data;
				REG_KEY_PART_1: kp_q[1] <= cfg_data;
				REG_KEY_PART_2: kp_q[2] <= cfg_data;
				REG_KEY_PART_3: kp_q[3] <= cfg_data;
				default: ;
			endcase
			busy_q <= 1'b1;
			cnt_q <= '0;
			mod_q <= '0;
			rc_q <= RCON_INIT;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 6'd1;
			mod_q <= wrap ? 3'd0 : mod_q + 3'd1;
			if (mod_q == 3'd0 && {2'b00, cnt_q} >= 8'(nk))
				rc_q <= xtime(rc_q);
			if (cnt_q == total - 6'd1)
				busy_q <= 1'b0;
		end
	end

	// window of recent words and the round key store
	always_ff @(posedge clk) begin
		if (start) begin
			for (int r = 0; r < NUM_RK; r++) rk_q[r] <= '0;
		end else if (busy_q) begin
			win_q[0] <= word;
			for (int k = 1; k < 8; k++) win_q[k] <= win_q[k-1];
			for (int r = 0; r < NUM_RK; r++) begin
				for (int c = 0; c < 4; c++) begin
					if (cnt_q == 6'(4 * r + c))
						rk_q[r][127 - 32 * c -: 32] <= word;
				end
			end
		end
	end

	assign round_keys = rk_q;
	assign status = '{busy: busy_q, klen: klen_q};

endmodule

// ===== rtl/aes_round.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_round
// one forward or inverse cipher round, passes the state when unused
// ----------------------------------------------------------------------------
module aes_round import aes_pkg::*; (
	input  logic [127:0] state_in,
	input  logic         dec,
	input  logic         active,
	input  logic         last,
	input  rkey_t        enc_key,
	input  rkey_t        dec_key,
	output logic [127:0] state_out
);

	logic [7:0] s [16];
	logic [7:0] t [16];
	logic [7:0] m [16];
	logic [7:0] a, b, d, e, x;
	logic [7:0] a2, a4, a8, b2, b4, b8, d2, d4, d8, e2, e4, e8;
	logic [127:0] res;

	always_comb begin
		for (int i = 0; i < 16; i++) s[i] = state_in[127 - 8 * i -: 8];
		for (int i = 0; i < 16; i++) begin
			if (dec)
				t[(i + 4 * (i % 4)) % 16] = inv_sbox(s[i]);
			else
				t[i] = sbox(s[(i + 4 * (i % 4)) % 16]);
		end
		// decrypt adds the key before the inverse mix
		if (dec)
			for (int i = 0; i < 16; i++) t[i] = t[i] ^ dec_key[127 - 8 * i -: 8];
		for (int c = 0; c < 4; c++) begin
			a = t[4*c]; b = t[4*c+1]; d = t[4*c+2]; e = t[4*c+3];
			x = a ^ b ^ d ^ e;
			a2 = xtime(a); a4 = xtime(a2); a8 = xtime(a4);
			b2 = xtime(b); b4 = xtime(b2); b8 = xtime(b4);
			d2 = xtime(d); d4 = xtime(d2); d8 = xtime(d4);
			e2 = xtime(e); e4 = xtime(e2); e8 = xtime(e4);
			if (dec) begin
				m[4*c]   = (a8^a4^a2) ^ (b8^b2^b) ^ (d8^d4^d) ^ (e8^e);
				m[4*c+1] = (a8^a) ^ (b8^b4^b2) ^ (d8^d2^d) ^ (e8^e4^e);
				m[4*c+2] = (a8^a4^a) ^ (b8^b) ^ (d8^d4^d2) ^ (e8^e2^e);
				m[4*c+3] = (a8^a2^a) ^ (b8^b4^b) ^ (d8^d) ^ (e8^e4^e2);
			end else begin
				m[4*c]   = a ^ x ^ xtime(a ^ b);
				m[4*c+1] = b ^ x ^ xtime(b ^ d);
				m[4*c+2] = d ^ x ^ xtime(d ^ e);
				m[4*c+3] = e ^ x ^ xtime(e ^ a);
			end
		end
		for (int i = 0; i < 16; i++) begin
			if (last) res[127 - 8 * i -: 8] = t[i];
			else res[127 - 8 * i -: 8] = m[i];
		end
		if (!dec) res = res ^ enc_key;
		state_out = active ? res : state_in;
	end

endmodule

// ===== rtl/aes_block_cipher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_block_cipher
// aes-128/192/256 single block cipher, both directions, fully unrolled
// ----------------------------------------------------------------------------
// each block is registered in stage 0 and then in every round stage, for every key size
// one block per cycle while neither a stalled result nor the key expansion holds input,
// one round per pipeline stage; reset and every key register write start the key
// expansion, one schedule word per cycle, with in_ready low until all 44, 52 or 60
// schedule words are done; a stalled result holds the whole pipeline in place
module aes_block_cipher import aes_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        decrypt,
	input  logic [63:0] block_high,
	input  logic [63:0] block_low,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] result_high,
	output logic [63:0] result_low,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	rkey_t       round_keys [NUM_RK];
	key_status_t key_st;

	// stage 0 holds the initial key add, stage j holds round j
	logic [127:0] blk_s [MAX_ROUNDS + 1];
	logic         vld_s [MAX_ROUNDS + 1];
	logic         dec_s [MAX_ROUNDS + 1];
	logic [127:0] init_blk;
	logic [127:0] nxt [1:MAX_ROUNDS];
	rkey_t        dkey [MAX_ROUNDS + 1];
	logic [3:0]   nr;
	logic         adv;

	aes_key_expand u_key (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.round_keys (round_keys),
		.status     (key_st)
	);

	// pipeline moves whenever the output slot is empty or being taken
	assign adv = !vld_s[MAX_ROUNDS] || out_ready;
	assign in_ready = adv && !key_st.busy;

	// decrypt walks the schedule backward from round nr
	always_comb begin
		unique case (key_st.klen)
			KLEN_128: nr = 4'd10;
			KLEN_192: nr = 4'd12;
			default:  nr = 4'd14;
		endcase
		for (int j = 0; j <= MAX_ROUNDS; j++) begin
			unique case (key_st.klen)
				KLEN_128: dkey[j] = round_keys[(10 + NUM_RK - j) % NUM_RK];
				KLEN_192: dkey[j] = round_keys[(12 + NUM_RK - j) % NUM_RK];
				default:  dkey[j] = round_keys[(14 + NUM_RK - j) % NUM_RK];
			endcase
		end
		init_blk = {block_high, block_low} ^ (decrypt ? dkey[0] : round_keys[0]);
	end

	for (genvar j = 1; j <= MAX_ROUNDS; j++) begin : g_round
		aes_round u_round (
			.state_in  (blk_s[j-1]),
			.dec       (dec_s[j-1]),
			.active    (4'(j) <= nr),
			.last      (4'(j) == nr),
			.enc_key   (round_keys[j]),
			.dec_key   (dkey[j]),
			.state_out (nxt[j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= MAX_ROUNDS; j++) vld_s[j] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= in_valid && in_ready;
			for (int j = 1; j <= MAX_ROUNDS; j++) vld_s[j] <= vld_s[j-1];
		end
	end

	// payload carries no reset
	always_ff @(posedge clk) begin
		if (adv) begin
			blk_s[0] <= init_blk;
			dec_s[0] <= decrypt;
			for (int j = 1; j <= MAX_ROUNDS; j++) begin
				blk_s[j] <= nxt[j];
				dec_s[j] <= dec_s[j-1];
			end
		end
	end

	assign out_valid = vld_s[MAX_ROUNDS];
	assign result_high = blk_s[MAX_ROUNDS][127:64];
	assign result_low = blk_s[MAX_ROUNDS][63:0];

endmodule

// ===== dv/aes_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_checker
// watches the block, key and result channels, predicts each result block
// from its own key schedule and compares both result halves in order
// ----------------------------------------------------------------------------
module aes_checker import aes_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        decrypt,
	input  logic [63:0] block_high,
	input  logic [63:0] block_low,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [63:0] result_high,
	input  logic [63:0] result_low,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output int          errors,
	output int          pending
);

	logic [7:0]   fwd_sub [256];
	logic [7:0]   inv_sub [256];
	logic [31:0]  sched [60];
	logic [1:0]   key_len;
	logic [63:0]  key_word [4];
	logic [127:0] expected_blocks [$];

	function automatic logic [7:0] gf_double(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mult(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		p = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i])
				p ^= a;
			a = gf_double(a);
		end
		return p;
	endfunction

	function automatic logic [7:0] rotl8(input logic [7:0] b, input int n);
		return (b << n) | (b >> (8 - n));
	endfunction

	// substitution tables from the field inverse and the affine map
	initial begin
		logic [7:0] y;
		for (int x = 0; x < 256; x++) begin
			y = 8'h00;
			for (int c = 1; c < 256; c++)
				if (x != 0 && gf_mult(x[7:0], c[7:0]) == 8'h01)
					y = c[7:0];
			fwd_sub[x] = y ^ rotl8(y, 1) ^ rotl8(y, 2) ^ rotl8(y, 3) ^ rotl8(y, 4) ^ 8'h63;
		end
		for (int x = 0; x < 256; x++)
			inv_sub[fwd_sub[x]] = x[7:0];
	end

	function automatic int key_words();
		return key_len == KLEN_128 ? 4 : (key_len == KLEN_192 ? 6 : 8);
	endfunction

	function automatic logic [31:0] sub_bytes_word(input logic [31:0] w);
		return {fwd_sub[w[31:24]], fwd_sub[w[23:16]], fwd_sub[w[15:8]], fwd_sub[w[7:0]]};
	endfunction

	task automatic rebuild_schedule();
		int nk;
		int total;
		logic [7:0] rc;
		logic [31:0] t;
		nk = key_words();
		total = 4 * (nk + 7);
		rc = 8'h01;
		for (int i = 0; i < 60; i++)
			sched[i] = 32'h0;
		for (int i = 0; i < nk; i++)
			sched[i] = (i % 2) ? key_word[i / 2][31:0] : key_word[i / 2][63:32];
		for (int i = nk; i < total; i++) begin
			t = sched[i - 1];
			if (i % nk == 0) begin
				t = sub_bytes_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
				rc = gf_double(rc);
			end else if (nk > 6 && i % nk == 4) begin
				t = sub_bytes_word(t);
			end
			sched[i] = sched[i - nk] ^ t;
		end
	endtask

	function automatic logic [127:0] cipher_block(input logic dec, input logic [127:0] blk);
		logic [7:0] st [16];
		logic [7:0] tmp [16];
		logic [7:0] a, b, d, e, x;
		logic [31:0] k;
		logic [127:0] res;
		int nr;
		nr = key_words() + 6;
		for (int i = 0; i < 16; i++)
			st[i] = blk[127 - 8 * i -: 8];
		if (!dec) begin
			for (int r = 0; r <= nr; r++) begin
				if (r > 0) begin
					for (int i = 0; i < 16; i++)
						tmp[i] = fwd_sub[st[(i + 4 * (i % 4)) % 16]];
					if (r < nr) begin
						for (int c = 0; c < 4; c++) begin
							a = tmp[4*c]; b = tmp[4*c+1]; d = tmp[4*c+2]; e = tmp[4*c+3];
							x = a ^ b ^ d ^ e;
							tmp[4*c]   = a ^ x ^ gf_double(a ^ b);
							tmp[4*c+1] = b ^ x ^ gf_double(b ^ d);
							tmp[4*c+2] = d ^ x ^ gf_double(d ^ e);
							tmp[4*c+3] = e ^ x ^ gf_double(e ^ a);
						end
					end
					st = tmp;
				end
				for (int c = 0; c < 4; c++) begin
					k = sched[(r * 4 + c) % 60];
					for (int j = 0; j < 4; j++)
						st[4*c+j] ^= k[31 - 8 * j -: 8];
				end
			end
		end else begin
			for (int r = nr; r >= 0; r--) begin
				if (r < nr) begin
					for (int i = 0; i < 16; i++)
						tmp[(i + 4 * (i % 4)) % 16] = inv_sub[st[i]];
					st = tmp;
				end
				for (int c = 0; c < 4; c++) begin
					k = sched[(r * 4 + c) % 60];
					for (int j = 0; j < 4; j++)
						st[4*c+j] ^= k[31 - 8 * j -: 8];
				end
				if (r < nr && r > 0) begin
					for (int c = 0; c < 4; c++) begin
						a = st[4*c]; b = st[4*c+1]; d = st[4*c+2]; e = st[4*c+3];
						st[4*c]   = gf_mult(a, 8'd14) ^ gf_mult(b, 8'd11) ^
							gf_mult(d, 8'd13) ^ gf_mult(e, 8'd9);
						st[4*c+1] = gf_mult(a, 8'd9) ^ gf_mult(b, 8'd14) ^
							gf_mult(d, 8'd11) ^ gf_mult(e, 8'd13);
						st[4*c+2] = gf_mult(a, 8'd13) ^ gf_mult(b, 8'd9) ^
							gf_mult(d, 8'd14) ^ gf_mult(e, 8'd11);
						st[4*c+3] = gf_mult(a, 8'd11) ^ gf_mult(b, 8'd13) ^
							gf_mult(d, 8'd9) ^ gf_mult(e, 8'd14);
					end
				end
			end
		end
		for (int i = 0; i < 16; i++)
			res[127 - 8 * i -: 8] = st[i];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [127:0] exp_blk;
		if (!arst_n) begin
			key_len = KLEN_128;
			for (int i = 0; i < 4; i++)
				key_word[i] = 64'h0;
			rebuild_schedule();
			expected_blocks.delete();
			errors = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_KEY_LENGTH: key_len = cfg_data[1:0];
					REG_KEY_PART_0: key_word[0] = cfg_data;
					REG_KEY_PART_1: key_word[1] = cfg_data;
					REG_KEY_PART_2: key_word[2] = cfg_data;
					REG_KEY_PART_3: key_word[3] = cfg_data;
					default: ;
				endcase
				rebuild_schedule();
			end
			if (in_valid && in_ready)
				expected_blocks.push_back(cipher_block(decrypt, {block_high, block_low}));
			if (out_valid && out_ready) begin
				if (expected_blocks.size() == 0) begin
					$error("result_high: no result expected, actual %h", result_high);
					errors++;
				end else begin
					exp_blk = expected_blocks.pop_front();
					if (result_high !== exp_blk[127:64]) begin
						$error("result_high: expected %h actual %h", exp_blk[127:64], result_high);
						errors++;
					end
					if (result_low !== exp_blk[63:0]) begin
						$error("result_low: expected %h actual %h", exp_blk[63:0], result_low);
						errors++;
					end
				end
			end
		end
		pending = expected_blocks.size();
	end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// block cipher bench: directed and random blocks in both directions under
// several key sizes and keys, with bursty input and stalling output
// ----------------------------------------------------------------------------
module tb import aes_pkg::*; ();

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        decrypt;
	logic [63:0] block_high;
	logic [63:0] block_low;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] result_high;
	logic [63:0] result_low;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;
	int          errors;
	int          pending;
	int          hold_req;

	// first index past the register map, writes there must be ignored
	localparam logic [2:0] REG_UNUSED = REG_KEY_PART_3 + 3'd1;
	// highest index the port can carry
	localparam logic [2:0] REG_TOP = 3'd7;
	// spare key length code, acts as a 256-bit key
	localparam logic [1:0] KLEN_SPARE = KLEN_256 + 2'd1;

	aes_block_cipher DUT (.*);
	aes_checker u_checker (.*);

	// 10 ns clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// generous overall limit
	initial begin
		#5ms;
		$display("*** FAILED ***");
		$finish;
	end

	// result side: the stall pattern is redrawn at random from four modes, plus a long hold-off on request
	initial begin
		int mode;
		int hold_seen;
		out_ready = 1'b0;
		hold_seen = 0;
		forever begin
			mode = $urandom_range(0, 3);
			for (int i = 0; i < 64; i++) begin
				@(posedge clk);
				if (hold_req != hold_seen) begin
					// hold the output long enough for the pipeline to fill and stall input
					out_ready <= 1'b0;
					repeat (300) @(posedge clk);
					hold_seen = hold_req;
				end
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= ($urandom_range(0, 3) != 0);
					default: out_ready <= (i % 8) < 5;
				endcase
			end
		end
	end

	// one block transfer; valid stays high for the caller's next block
	task automatic send_block(input logic dec, input logic [63:0] hi, input logic [63:0] lo);
		in_valid   <= 1'b1;
		decrypt    <= dec;
		block_high <= hi;
		block_low  <= lo;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic idle_input(input int cycles);
		if (cycles > 0) begin
			in_valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// wait for every result, then for the pipeline depth
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	task automatic reg_idle();
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_key(input logic [1:0] len, input logic [63:0] k0, input logic [63:0] k1,
		input logic [63:0] k2, input logic [63:0] k3);
		reg_write(REG_KEY_LENGTH, {62'h0, len});
		reg_write(REG_KEY_PART_0, k0);
		reg_write(REG_KEY_PART_1, k1);
		reg_write(REG_KEY_PART_2, k2);
		reg_write(REG_KEY_PART_3, k3);
		reg_idle();
	endtask

	function automatic logic [63:0] rand64();
		case ($urandom_range(0, 9))
			0: return 64'h0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// random blocks in bursts with random gaps
	task automatic random_blocks(input int count);
		int left;
		int burst;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 24);
			if (burst > left)
				burst = left;
			for (int i = 0; i < burst; i++)
				send_block(1'($urandom_range(0, 1)), rand64(), rand64());
			left -= burst;
			if ($urandom_range(0, 3) != 0)
				idle_input($urandom_range(1, 8));
		end
	endtask

	initial begin
		logic [63:0] pattern [6];
		pattern = '{64'h0, '1, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa,
			64'h0001020304050607, 64'h8000000000000001};
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		decrypt    = 1'b0;
		block_high = 64'h0;
		block_low  = 64'h0;
		cfg_we     = 1'b0;
		cfg_index  = REG_KEY_LENGTH;
		cfg_data   = 64'h0;
		hold_req   = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset key (all zero, 128 bit), extreme blocks both directions
		for (int i = 0; i < 6; i++) begin
			send_block(1'b0, pattern[i], pattern[5 - i]);
			send_block(1'b1, pattern[5 - i], pattern[i]);
		end
		drain();

		// key length three acts as a 256-bit key, all-ones key
		load_key(KLEN_SPARE, '1, '1, '1, '1);
		send_block(1'b0, 64'h0, 64'h0);
		send_block(1'b1, '1, '1);
		drain();

		// writes past the register map leave the schedule alone
		reg_write(REG_UNUSED, '1);
		reg_write(REG_TOP, 64'h0123456789abcdef);
		reg_idle();
		send_block(1'b0, 64'h00112233_44556677, 64'h8899aabb_ccddeeff);
		send_block(1'b1, 64'h00112233_44556677, 64'h8899aabb_ccddeeff);
		drain();

		// partial key update: mixed key in force after one part changes
		reg_write(REG_KEY_PART_0, 64'h0102030405060708);
		reg_idle();
		send_block(1'b0, 64'h0, '1);
		drain();
		load_key(KLEN_192, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
			64'h1011121314151617, 64'h0);
		send_block(1'b0, 64'h00112233_44556677, 64'h8899aabb_ccddeeff);
		send_block(1'b1, '1, 64'h0);
		drain();

		// random phases across key sizes and keys
		for (int ph = 0; ph < 8; ph++) begin
			if (ph == 1)
				load_key(KLEN_128, 64'h0, 64'h0, 64'h0, 64'h0);
			else if (ph == 2)
				load_key(KLEN_256, '1, '1, '1, '1);
			else
				load_key(2'($urandom_range(0, 3)), rand64(), rand64(), rand64(), rand64());
			if (ph == 3)
				hold_req++;
			random_blocks(120);
			// on even phases the sender pauses until every expected result is back
			if (ph % 2 == 0)
				drain();
			random_blocks(120);
			drain();
		end

		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
